FILE: rtl/flrh_pkg.sv
package flrh_pkg;

    // full words counted since the last first beat
    localparam int IDX_W = 29;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] PHI   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MUL_A = 64'h85EB_CA77_C2B2_AE3D;
    localparam logic [63:0] MUL_B = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MUL_C = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] MUL_D = 64'hA3C8_B9D5_E1F2_A7B4;

    // left rotation per lane
    localparam int ROT0 = 11;
    localparam int ROT1 = 19;
    localparam int ROT2 = 35;
    localparam int ROT3 = 47;

    // one classified beat, as handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        absorb;
        logic [1:0]  lane;
        logic [63:0] data;
        logic [31:0] len;
        logic [63:0] seed;
    } op_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    // lane set-up multipliers
    function automatic logic [63:0] init_mul(input logic [1:0] idx);
        logic [63:0] m;
        unique case (idx)
            2'd0: m = PHI;
            2'd1: m = MUL_A;
            2'd2: m = MUL_B;
            2'd3: m = MUL_C;
        endcase
        return m;
    endfunction

    // finaliser round multipliers
    function automatic logic [63:0] fin_mul(input logic [1:0] rnd);
        logic [63:0] m;
        unique case (rnd)
            2'd0: m = MUL_A;
            2'd1: m = MUL_B;
            2'd2: m = MUL_C;
            2'd3: m = MUL_D;
        endcase
        return m;
    endfunction

    // xor-shift that follows each finaliser multiply
    function automatic logic [63:0] fin_mix(input logic [1:0] rnd, input logic [63:0] t);
        logic [63:0] r;
        unique case (rnd)
            2'd0: r = t ^ (t >> 23);
            2'd1: r = t ^ (t >> 29);
            2'd2: r = t ^ (t >> 37);
            2'd3: r = t ^ (t >> 43);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/flrh_front.sv
module flrh_front #(
    parameter int LEN_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [63:0]       s_word,
    input  logic [3:0]        s_byte_count,
    input  logic              s_first,
    input  logic              s_last,
    input  logic [31:0]       s_message_length,
    input  logic [63:0]       s_seed_value,
    input  logic              q_full,
    output logic              push,
    output flrh_pkg::op_t     push_op
);
    import flrh_pkg::*;

    localparam int LEN_BITS = (LEN_WIDTH < 32) ? LEN_WIDTH : 32;
    localparam int BLK_W    = IDX_W - 2;

    logic [IDX_W-1:0]    word_index_reg, word_index_next;
    logic [LEN_BITS-1:0] length_held_reg, length_held_next;

    logic [LEN_BITS-1:0] len_in;
    logic [LEN_BITS-1:0] len_eff;
    logic [IDX_W-1:0]    idx_eff;
    logic [BLK_W-1:0]    blocks;
    logic [3:0]          cnt;
    logic                full_word;
    logic                in_block;
    logic [1:0]          lane;
    logic [63:0]         masked;
    logic [63:0]         rotated;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        len_in  = s_message_length[LEN_BITS-1:0];
        len_eff = s_first ? len_in : length_held_reg;
        idx_eff = s_first ? '0 : word_index_reg;

        // oversized counts behave as a full word
        cnt       = s_byte_count[3] ? 4'd8 : s_byte_count;
        full_word = s_byte_count[3];

        for (int i = 0; i < 8; i++) begin
            masked[i*8 +: 8] = (4'(i) < cnt) ? s_word[i*8 +: 8] : 8'h00;
        end

        // inside the complete 32-byte blocks when index/4 < length/32
        blocks   = BLK_W'(len_eff >> 5);
        in_block = idx_eff[IDX_W-1:2] < blocks;
        lane     = (full_word && in_block) ? idx_eff[1:0] : 2'd0;

        unique case (lane)
            2'd0: rotated = (masked << ROT0) | (masked >> (64 - ROT0));
            2'd1: rotated = (masked << ROT1) | (masked >> (64 - ROT1));
            2'd2: rotated = (masked << ROT2) | (masked >> (64 - ROT2));
            2'd3: rotated = (masked << ROT3) | (masked >> (64 - ROT3));
        endcase

        push_op.first  = s_first;
        push_op.last   = s_last;
        push_op.absorb = (cnt != 4'd0);
        push_op.lane   = lane;
        push_op.data   = rotated;
        push_op.len    = 32'(len_in);
        push_op.seed   = s_seed_value;

        word_index_next  = word_index_reg;
        length_held_next = length_held_reg;
        if (push) begin
            length_held_next = len_eff;
            word_index_next  = full_word ? idx_eff + 1'b1 : idx_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg  <= '0;
            length_held_reg <= '0;
        end else begin
            word_index_reg  <= word_index_next;
            length_held_reg <= length_held_next;
        end
    end

endmodule

FILE: rtl/flrh_queue.sv
module flrh_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  flrh_pkg::op_t     push_op,
    output logic              full,
    input  logic              pop,
    output flrh_pkg::q_head_t head
);
    import flrh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("back end popped an empty queue");

endmodule

FILE: rtl/flrh_mul.sv
module flrh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);
    localparam logic [1:0] ST_LL   = 2'd0;
    localparam logic [1:0] ST_LH   = 2'd1;
    localparam logic [1:0] ST_HL   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  step_reg, step_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] x, y;
    logic [63:0] pp;

    // low 64 bits of a*b: lo*lo, then the two cross terms shifted up
    always_comb begin
        unique case (step_reg)
            ST_LL:   begin x = a[31:0];  y = b[31:0];  end
            ST_LH:   begin x = a[31:0];  y = b[63:32]; end
            ST_HL:   begin x = a[63:32]; y = b[31:0];  end
            ST_DONE: begin x = a[31:0];  y = b[31:0];  end
        endcase
        pp = 64'(x) * 64'(y);

        unique case (step_reg)
            ST_LL:   prod_next = pp;
            ST_LH:   prod_next = prod_reg + {pp[31:0], 32'h0};
            ST_HL:   prod_next = prod_reg + {pp[31:0], 32'h0};
            ST_DONE: prod_next = prod_reg;
        endcase

        step_next = go ? step_reg + 1'b1 : ST_LL;
    end

    assign done = go && (step_reg == ST_DONE);
    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_LL;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/flrh_back.sv
module flrh_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  flrh_pkg::q_head_t head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_hash
);
    import flrh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BASE = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_MIX  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    op_t         op_reg, op_next;
    logic [63:0] base_reg, base_next;
    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [63:0] h_reg, h_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_hash_reg, m_hash_next;

    logic        mul_go, mul_done;
    logic [63:0] mul_a, mul_b, mul_prod;
    logic [63:0] lanes_x;
    logic        out_free;

    flrh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign mul_go   = (state_reg == S_BASE) || (state_reg == S_INIT) ||
                      (state_reg == S_ABS)  || (state_reg == S_FIN);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_hash   = m_hash_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        h_next       = h_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_hash_next  = m_hash_reg;
        pop          = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        lanes_x      = acc_reg[0] ^ acc_reg[1] ^ acc_reg[2] ^ acc_reg[3];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (head.valid) begin
                    pop     = 1'b1;
                    op_next = head.op;
                    if (head.op.first) begin
                        state_next = S_BASE;
                    end else if (head.op.absorb) begin
                        state_next = S_ABS;
                    end else if (head.op.last) begin
                        state_next = S_MIX;
                    end
                end
            end
            S_BASE: begin
                mul_a = 64'(op_reg.len);
                mul_b = PHI;
                if (mul_done) begin
                    base_next  = op_reg.seed ^ mul_prod;
                    cnt_next   = 2'd0;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                mul_a = base_reg;
                mul_b = init_mul(cnt_reg);
                if (mul_done) begin
                    acc_next[cnt_reg] = mul_prod;
                    cnt_next          = cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3) begin
                        if (op_reg.absorb) begin
                            state_next = S_ABS;
                        end else if (op_reg.last) begin
                            state_next = S_MIX;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_ABS: begin
                mul_a = acc_reg[op_reg.lane] ^ op_reg.data;
                mul_b = PHI;
                if (mul_done) begin
                    acc_next[op_reg.lane] = mul_prod;
                    state_next = op_reg.last ? S_MIX : S_IDLE;
                end
            end
            S_MIX: begin
                h_next     = lanes_x ^ (lanes_x >> 17);
                cnt_next   = 2'd0;
                state_next = S_FIN;
            end
            S_FIN: begin
                mul_a = h_reg;
                mul_b = fin_mul(cnt_reg);
                if (mul_done) begin
                    h_next   = fin_mix(cnt_reg, mul_prod);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3) begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_hash_next  = h_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        base_reg   <= base_next;
        h_reg      <= h_next;
        cnt_reg    <= cnt_next;
        m_hash_reg <= m_hash_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
        end
    end

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> m_valid_reg)
        else $error("finished hash not placed in output register");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

endmodule

FILE: rtl/four_lane_rotate_hash_v2.sv
// channel | direction | handshake           | beat carries
// s_      | in        | s_valid / s_ready   | word, byte_count, first, last, length, seed
// m_      | out       | m_valid / m_ready   | 64-bit hash, one per beat marked last
//
// one shared 32x32 multiplier does every 64-bit product
// a plain word beat in the back end is a queue pop plus one product
// first adds base plus four lane set-ups, last adds mix, four rounds and output
// reset clears lanes, word index, held length, queue and output valid flag at once
// the front takes beats while the queue has room; a held result stalls the back end, and the front once the queue fills
module four_lane_rotate_hash_v2 #(
    parameter int LEN_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [31:0] s_message_length,
    input  logic [63:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash
);
    import flrh_pkg::*;

    // front to queue
    logic    q_full;
    logic    q_push;
    op_t     q_push_op;

    // queue to back
    q_head_t q_head;
    logic    q_pop;

    // classifies each beat: byte mask, lane choice, rotation, word index
    flrh_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_word           (s_word),
        .s_byte_count     (s_byte_count),
        .s_first          (s_first),
        .s_last           (s_last),
        .s_message_length (s_message_length),
        .s_seed_value     (s_seed_value),
        .q_full           (q_full),
        .push             (q_push),
        .push_op          (q_push_op)
    );

    // short queue so the front keeps taking beats while products run
    flrh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    // lane set-up, absorption, finaliser and output register
    flrh_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_hash  (m_hash)
    );

endmodule
